// ----- hdl/rcos_pkg.sv -----
`default_nettype none
package rcos_pkg;

	typedef enum logic [1:0] {
		ACT_NONE        = 2'd0,
		ACT_SCHED       = 2'd1,
		ACT_EMIT_SCHED  = 2'd2,
		ACT_EMIT_RESYNC = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_OUT_NUM = 2'd0,
		REG_OUT_DEN = 2'd1,
		REG_IN_NUM  = 2'd2,
		REG_IN_DEN  = 2'd3
	} reg_index_t;

	// restoring divider state: remainder and dividend/quotient shift word
	typedef struct packed {
		logic [15:0] rem;
		logic [63:0] x;
	} div_t;

	function automatic div_t div_step(input div_t i, input logic [15:0] den);
		logic [16:0] t;
		div_t        o;
		t   = {i.rem, i.x[63]};
		o.x = {i.x[62:0], 1'b0};
		if (t >= {1'b0, den}) begin
			o.rem  = 16'(t - {1'b0, den});
			o.x[0] = 1'b1;
		end else begin
			o.rem = t[15:0];
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ratio_clock_output_scheduler.sv -----
// throughput: one request per cycle unless the result is stalled; each bit-per-stage
// divider (58 and 64 stages) and the split 64-bit multiplies are fully pipelined
// a stalled result holds the whole pipeline, no request is lost
// reset: pipeline emptied, all ratio registers return to 1
`default_nettype none
module ratio_clock_output_scheduler
	import rcos_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [40:0] last_out_tick,
	input  wire logic signed [40:0] last_in_tick,
	input  wire logic [31:0]        avg_in_period,
	input  wire logic [31:0]        in_tick_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              action,
	output logic [31:0]             next_time
);

	localparam int DW1 = 58;
	localparam int DW2 = 64;

	logic [15:0] onum_q, oden_q, inum_q, iden_q;
	logic        en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// a register written as zero behaves as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onum_q <= 16'd1;
			oden_q <= 16'd1;
			inum_q <= 16'd1;
			iden_q <= 16'd1;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_OUT_NUM: onum_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				REG_OUT_DEN: oden_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				REG_IN_NUM:  inum_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				REG_IN_DEN:  iden_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	logic               v_s1;
	logic signed [40:0] lo_s1, li_s1;
	logic [31:0]        avg_s1, tin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1  <= last_out_tick;
			li_s1  <= last_in_tick;
			avg_s1 <= avg_in_period;
			tin_s1 <= in_tick_time;
		end
	end

	// stage 2: ratio products, split into sign and magnitude
	logic signed [57:0] pc;
	logic signed [41:0] lo1, lo2;
	logic signed [58:0] pa, pb;
	always_comb begin
		pc  = li_s1 * $signed({1'b0, inum_q});
		lo1 = {lo_s1[40], lo_s1} + 42'sd1;
		lo2 = {lo_s1[40], lo_s1} + 42'sd2;
		pa  = lo1 * $signed({1'b0, onum_q});
		pb  = lo2 * $signed({1'b0, onum_q});
	end

	logic              v_s2;
	logic [DW1-1:0]    mc_s2, ma_s2, mb_s2;
	logic              sc_s2, sa_s2, sb_s2;
	logic [31:0]       avg_s2, tin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sc_s2  <= pc[57];
			sa_s2  <= pa[58];
			sb_s2  <= pb[58];
			mc_s2  <= pc[57] ? DW1'(-pc) : DW1'(pc);
			ma_s2  <= pa[58] ? DW1'(-pa) : DW1'(pa);
			mb_s2  <= pb[58] ? DW1'(-pb) : DW1'(pb);
			avg_s2 <= avg_s1;
			tin_s2 <= tin_s1;
		end
	end

	// tick mapping dividers, one quotient bit per stage
	div_t        dc_s [0:DW1];
	div_t        da_s [0:DW1];
	div_t        db_s [0:DW1];
	logic        sc_s [0:DW1];
	logic        sa_s [0:DW1];
	logic        sb_s [0:DW1];
	logic [31:0] avg_s[0:DW1];
	logic [31:0] tin_s[0:DW1];
	logic        vd_s [0:DW1];

	assign dc_s[0]  = '{rem: 16'd0, x: {mc_s2, {(64-DW1){1'b0}}}};
	assign da_s[0]  = '{rem: 16'd0, x: {ma_s2, {(64-DW1){1'b0}}}};
	assign db_s[0]  = '{rem: 16'd0, x: {mb_s2, {(64-DW1){1'b0}}}};
	assign sc_s[0]  = sc_s2;
	assign sa_s[0]  = sa_s2;
	assign sb_s[0]  = sb_s2;
	assign avg_s[0] = avg_s2;
	assign tin_s[0] = tin_s2;
	assign vd_s[0]  = v_s2;

	for (genvar k = 0; k < DW1; k++) begin : g_div1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_s[k+1] <= 1'b0;
			else if (en) vd_s[k+1] <= vd_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dc_s[k+1]  <= div_step(dc_s[k], iden_q);
				da_s[k+1]  <= div_step(da_s[k], oden_q);
				db_s[k+1]  <= div_step(db_s[k], oden_q);
				sc_s[k+1]  <= sc_s[k];
				sa_s[k+1]  <= sa_s[k];
				sb_s[k+1]  <= sb_s[k];
				avg_s[k+1] <= avg_s[k];
				tin_s[k+1] <= tin_s[k];
			end
		end
	end

	// stage 3: restore signs, truncation toward zero
	logic [DW1-1:0]     qc, qa, qb;
	logic               v_s3;
	logic signed [58:0] cur_s3, ta_s3, tb_s3;
	logic [31:0]        avg_s3, tin_s3;

	assign qc = dc_s[DW1].x[DW1-1:0];
	assign qa = da_s[DW1].x[DW1-1:0];
	assign qb = db_s[DW1].x[DW1-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= vd_s[DW1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cur_s3 <= sc_s[DW1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
			ta_s3  <= sa_s[DW1] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
			tb_s3  <= sb_s[DW1] ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
			avg_s3 <= avg_s[DW1];
			tin_s3 <= tin_s[DW1];
		end
	end

	// stage 4: emit decision and distance to target
	logic               emit, resync, ok;
	logic signed [58:0] tgt;
	logic signed [59:0] dd;
	action_t            act;
	always_comb begin
		emit   = (ta_s3 <= cur_s3);
		resync = emit && (tb_s3 < cur_s3);
		tgt    = emit ? tb_s3 : ta_s3;
		dd     = {tgt[58], tgt} - {cur_s3[58], cur_s3};
		ok     = !dd[59] && (avg_s3 != 32'd0);
		if (resync)   act = ACT_EMIT_RESYNC;
		else if (ok)  act = emit ? ACT_EMIT_SCHED : ACT_SCHED;
		else if (emit) act = ACT_EMIT_RESYNC;
		else          act = ACT_NONE;
	end

	logic        v_s4;
	logic [63:0] d_s4;
	logic [31:0] avg_s4, tin_s4;
	action_t     act_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s4   <= (act == ACT_SCHED || act == ACT_EMIT_SCHED) ? {4'd0, dd} : 64'd0;
			act_s4 <= act;
			avg_s4 <= avg_s3;
			tin_s4 <= tin_s3;
		end
	end

	// stages 5 to 8: d * avg * den modulo 2^64 as split products
	logic        v_s5, v_s6, v_s7, v_s8;
	logic [63:0] m0_s5, p_s6, p2_s8;
	logic [31:0] m1_s5, n1_s7;
	logic [47:0] n0_s7;
	logic [31:0] tin_s5, tin_s6, tin_s7, tin_s8;
	action_t     act_s5, act_s6, act_s7, act_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m0_s5  <= d_s4[31:0] * avg_s4;
			m1_s5  <= 32'(d_s4[63:32] * avg_s4);
			p_s6   <= m0_s5 + {m1_s5, 32'd0};
			n0_s7  <= p_s6[31:0] * iden_q;
			n1_s7  <= 32'(p_s6[63:32] * iden_q);
			p2_s8  <= {16'd0, n0_s7} + {n1_s7, 32'd0};
			tin_s5 <= tin_s4;
			tin_s6 <= tin_s5;
			tin_s7 <= tin_s6;
			tin_s8 <= tin_s7;
			act_s5 <= act_s4;
			act_s6 <= act_s5;
			act_s7 <= act_s6;
			act_s8 <= act_s7;
		end
	end

	// time offset divider by the input ratio numerator
	div_t        dt_s  [0:DW2];
	logic [31:0] tt_s  [0:DW2];
	action_t     at_s  [0:DW2];
	logic        vt_s  [0:DW2];

	assign dt_s[0] = '{rem: 16'd0, x: p2_s8};
	assign tt_s[0] = tin_s8;
	assign at_s[0] = act_s8;
	assign vt_s[0] = v_s8;

	for (genvar k = 0; k < DW2; k++) begin : g_div2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vt_s[k+1] <= 1'b0;
			else if (en) vt_s[k+1] <= vt_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dt_s[k+1] <= div_step(dt_s[k], inum_q);
				tt_s[k+1] <= tt_s[k];
				at_s[k+1] <= at_s[k];
			end
		end
	end

	// output register
	action_t act_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vt_s[DW2];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			act_q <= at_s[DW2];
			if (at_s[DW2] == ACT_SCHED || at_s[DW2] == ACT_EMIT_SCHED)
				next_time <= tt_s[DW2] + dt_s[DW2].x[31:0];
			else
				next_time <= 32'd0;
		end
	end
	assign action = act_q;

	// input only held back by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	a_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_NONE || action == ACT_EMIT_RESYNC))
		|-> (next_time == 32'd0))
		else $error("next_time set for an action that schedules nothing");

	a_ratio_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(onum_q != 16'd0) && (oden_q != 16'd0) && (inum_q != 16'd0) && (iden_q != 16'd0))
		else $error("ratio register holds zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(act_q) && $stable(next_time) && $stable(v_s8)))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire
